>>> design/prc_pkg.sv
// Shared types and constants for the posture rule classifier with debounce.
// Holds the class codes, register indexes, register reset values and the
// structs passed between the configuration, classifier and debounce modules.
package prc_pkg;

  typedef enum logic [2:0] {
    CLS_GOOD    = 3'd0,
    CLS_SLOUCH  = 3'd1,
    CLS_FORWARD = 3'd2,
    CLS_LEFT    = 3'd3,
    CLS_RIGHT   = 3'd4,
    CLS_TENSION = 3'd5,
    CLS_LUMBAR  = 3'd6,
    CLS_UNKNOWN = 3'd7
  } cls_t;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_LUMBAR  = 3'd0;
  localparam logic [2:0] REG_FORWARD = 3'd1;
  localparam logic [2:0] REG_SLOUCH  = 3'd2;
  localparam logic [2:0] REG_LEFT    = 3'd3;
  localparam logic [2:0] REG_RIGHT   = 3'd4;
  localparam logic [2:0] REG_TILT    = 3'd5;
  localparam logic [2:0] REG_WINDOW  = 3'd6;

  localparam logic [10:0] RST_LUMBAR  = 11'd200;
  localparam logic [11:0] RST_FORWARD = 12'd300;
  localparam logic [11:0] RST_SLOUCH  = 12'd150;
  localparam logic [11:0] RST_LEFT    = 12'hF6A;  // -150
  localparam logic [11:0] RST_RIGHT   = 12'd150;
  localparam logic [10:0] RST_TILT    = 11'd200;
  localparam logic [15:0] RST_WINDOW  = 16'd3000;

  typedef struct packed {
    logic [10:0] lumbar_limit;
    logic [11:0] forward_limit;
    logic [11:0] slouch_limit;
    logic [11:0] left_limit;
    logic [11:0] right_limit;
    logic [10:0] tilt_limit;
    logic [15:0] window_ms;
  } prc_cfg_t;

  typedef struct packed {
    logic        upper_valid;
    logic        lower_valid;
    logic        muscle_valid;
    logic        muscle_high;
    logic        flexion_valid;
    logic [11:0] flexion_angle;
    logic [11:0] pitch_dev;
    logic [11:0] roll_dev;
    logic [10:0] tilt_total;
    logic [31:0] time_ms;
  } prc_sample_t;

  typedef struct packed {
    logic [31:0] stamp_ms;
    cls_t        posture;
    cls_t        previous_posture;
    logic [31:0] time_in_posture;
    logic        correction_pulse;
    logic [31:0] correction_total;
  } prc_result_t;

endpackage

>>> design/posture_rule_classifier_debounce_top.sv
// Posture rule classifier with debounce, top level.
// Uses prc_pkg, prc_cfg_regs, prc_classify and prc_debounce.
//
// Usage:
//   Feature samples arrive as beats on the in_ stream; each beat yields exactly
//   one result beat on the out_ stream, in order. A sample is captured in an
//   input register, classified and debounced once the result register is
//   free, and its result lands in the output register. One beat per cycle is
//   sustained in both directions while out_tready stays high; the single pass
//   through the compares and the 32-bit time subtractions between the input
//   and output registers sets that figure.
//   When out_tready is low the result register holds, the input register fills
//   behind it, and in_tready drops only once both are full; no beat is lost.
//   Thresholds and the confirmation window are written over the cfg_ APB port
//   while the stream is idle; pready is always high.
//   Synchronous reset (rst_n low) empties both registers, restores the
//   register defaults and sets the candidate, confirmed and reported classes
//   to good with zero timestamps and a zero correction count.
module posture_rule_classifier_debounce_top
  import prc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, low bit up: muscle_high[0], flexion_angle[12:1], pitch_dev[24:13],
  // roll_dev[36:25], tilt_total[47:37], time_ms[79:48]
  input  logic [79:0]  in_tdata,
  // in_tuser, low bit up: upper_valid[0], lower_valid[1], muscle_valid[2],
  // flexion_valid[3]
  input  logic [3:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata, low bit up: stamp_ms[31:0], posture[34:32], previous_posture[37:35],
  // time_in_posture[69:38], correction_pulse[70], correction_total[102:71], zero[103]
  output logic [103:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  prc_cfg_t    cfg;
  prc_sample_t smp_r;
  logic        smp_vld_r;
  prc_result_t res;
  prc_result_t res_r;
  logic        res_vld_r;
  cls_t        raw_cls;
  logic        advance;
  logic        in_take;

  assign cfg_pready = 1'b1;

  prc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The sample in the input register moves on when the result register is free.
  assign advance   = smp_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !smp_vld_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (in_take) begin
      smp_vld_r <= 1'b1;
    end else if (advance) begin
      smp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r.upper_valid   <= in_tuser[0];
      smp_r.lower_valid   <= in_tuser[1];
      smp_r.muscle_valid  <= in_tuser[2];
      smp_r.flexion_valid <= in_tuser[3];
      smp_r.muscle_high   <= in_tdata[0];
      smp_r.flexion_angle <= in_tdata[12:1];
      smp_r.pitch_dev     <= in_tdata[24:13];
      smp_r.roll_dev      <= in_tdata[36:25];
      smp_r.tilt_total    <= in_tdata[47:37];
      smp_r.time_ms       <= in_tdata[79:48];
    end
  end

  prc_classify u_classify (
    .smp     (smp_r),
    .cfg     (cfg),
    .raw_cls (raw_cls)
  );

  prc_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .raw_cls   (raw_cls),
    .now_ms    (smp_r.time_ms),
    .window_ms (cfg.window_ms),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_tready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {1'b0,
                       res_r.correction_total,
                       res_r.correction_pulse,
                       res_r.time_in_posture,
                       res_r.previous_posture,
                       res_r.posture,
                       res_r.stamp_ms};

endmodule

>>> design/prc_cfg_regs.sv
// Configuration register file of the posture classifier, APB-style write and read.
// Depends on prc_pkg for the register indexes, reset values and prc_cfg_t.
module prc_cfg_regs
  import prc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output prc_cfg_t    cfg
);

  prc_cfg_t   cfg_r;
  prc_cfg_t   cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_LUMBAR:  cfg_nxt.lumbar_limit  = pwdata[10:0];
        REG_FORWARD: cfg_nxt.forward_limit = pwdata[11:0];
        REG_SLOUCH:  cfg_nxt.slouch_limit  = pwdata[11:0];
        REG_LEFT:    cfg_nxt.left_limit    = pwdata[11:0];
        REG_RIGHT:   cfg_nxt.right_limit   = pwdata[11:0];
        REG_TILT:    cfg_nxt.tilt_limit    = pwdata[10:0];
        REG_WINDOW:  cfg_nxt.window_ms     = pwdata[15:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lumbar_limit  <= RST_LUMBAR;
      cfg_r.forward_limit <= RST_FORWARD;
      cfg_r.slouch_limit  <= RST_SLOUCH;
      cfg_r.left_limit    <= RST_LEFT;
      cfg_r.right_limit   <= RST_RIGHT;
      cfg_r.tilt_limit    <= RST_TILT;
      cfg_r.window_ms     <= RST_WINDOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_LUMBAR:  prdata = {21'd0, cfg_r.lumbar_limit};
      REG_FORWARD: prdata = {20'd0, cfg_r.forward_limit};
      REG_SLOUCH:  prdata = {20'd0, cfg_r.slouch_limit};
      REG_LEFT:    prdata = {20'd0, cfg_r.left_limit};
      REG_RIGHT:   prdata = {20'd0, cfg_r.right_limit};
      REG_TILT:    prdata = {21'd0, cfg_r.tilt_limit};
      REG_WINDOW:  prdata = {16'd0, cfg_r.window_ms};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> design/prc_classify.sv
// Rule classifier: maps one feature sample to its raw posture class by a fixed
// priority of threshold compares. Depends on prc_pkg for cls_t and the structs.
module prc_classify
  import prc_pkg::*;
(
  input  prc_sample_t smp,
  input  prc_cfg_t    cfg,
  output cls_t        raw_cls
);

  logic lumbar_hit;
  logic forward_hit;
  logic slouch_hit;
  logic left_hit;
  logic right_hit;
  logic tilt_hit;

  // The lumbar limit is unsigned, so it is zero-extended before the signed compare.
  assign lumbar_hit  = $signed(smp.flexion_angle) >= $signed({1'b0, cfg.lumbar_limit});
  assign forward_hit = $signed(smp.pitch_dev) >= $signed(cfg.forward_limit);
  assign slouch_hit  = $signed(smp.pitch_dev) >= $signed(cfg.slouch_limit);
  assign left_hit    = $signed(smp.roll_dev) <= $signed(cfg.left_limit);
  assign right_hit   = $signed(smp.roll_dev) >= $signed(cfg.right_limit);
  assign tilt_hit    = smp.tilt_total >= cfg.tilt_limit;

  always_comb begin
    if (!smp.upper_valid && !smp.lower_valid) begin
      raw_cls = CLS_UNKNOWN;
    end else if (smp.muscle_valid && smp.muscle_high) begin
      raw_cls = CLS_TENSION;
    end else if (smp.flexion_valid && lumbar_hit) begin
      raw_cls = CLS_LUMBAR;
    end else if (smp.upper_valid && forward_hit) begin
      raw_cls = CLS_FORWARD;
    end else if (smp.upper_valid && slouch_hit) begin
      raw_cls = CLS_SLOUCH;
    end else if (smp.upper_valid && left_hit) begin
      raw_cls = CLS_LEFT;
    end else if (smp.upper_valid && right_hit) begin
      raw_cls = CLS_RIGHT;
    end else if (smp.upper_valid && tilt_hit) begin
      raw_cls = CLS_SLOUCH;
    end else begin
      raw_cls = CLS_GOOD;
    end
  end

endmodule

>>> design/prc_debounce.sv
// Debounce and report state: candidate tracking, confirmation window, correction
// pulse and counter. Depends on prc_pkg for cls_t and prc_result_t.
module prc_debounce
  import prc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  cls_t        raw_cls,
  input  logic [31:0] now_ms,
  input  logic [15:0] window_ms,
  output prc_result_t res
);

  cls_t        cand_r, cand_nxt;
  logic [31:0] cand_since_r, cand_since_nxt;
  cls_t        conf_r, conf_nxt;
  logic [31:0] conf_since_r, conf_since_nxt;
  logic        fired_r, fired_nxt;
  cls_t        last_r;
  logic [31:0] count_r, count_nxt;

  logic        cand_chg;
  logic        fired_eff;
  logic        held;
  logic        bad;
  logic        pulse;

  always_comb begin
    cand_chg       = raw_cls != cand_r;
    cand_nxt       = raw_cls;
    cand_since_nxt = cand_chg ? now_ms : cand_since_r;
    fired_eff      = cand_chg ? 1'b0 : fired_r;
    held           = (now_ms - cand_since_nxt) >= {16'd0, window_ms};

    conf_nxt       = conf_r;
    conf_since_nxt = conf_since_r;
    if (held && raw_cls != conf_r) begin
      conf_nxt       = raw_cls;
      conf_since_nxt = now_ms;
    end

    // A correction fires once per candidate run while the confirmed class is bad.
    bad       = conf_nxt != CLS_GOOD && conf_nxt != CLS_UNKNOWN;
    pulse     = bad && held && !fired_eff;
    fired_nxt = fired_eff | pulse;
    count_nxt = count_r + {31'd0, pulse};

    res.stamp_ms         = now_ms;
    res.posture          = conf_nxt;
    res.previous_posture = last_r;
    res.time_in_posture  = now_ms - conf_since_nxt;
    res.correction_pulse = pulse;
    res.correction_total = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r       <= CLS_GOOD;
      cand_since_r <= 32'd0;
      conf_r       <= CLS_GOOD;
      conf_since_r <= 32'd0;
      fired_r      <= 1'b0;
      last_r       <= CLS_GOOD;
      count_r      <= 32'd0;
    end else if (step) begin
      cand_r       <= cand_nxt;
      cand_since_r <= cand_since_nxt;
      conf_r       <= conf_nxt;
      conf_since_r <= conf_since_nxt;
      fired_r      <= fired_nxt;
      last_r       <= conf_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule
